[src/tfcp_pkg.sv]
// Package for the toroidal filled-circle painter: frame geometry, widths,
// operation codes, sequencer states and the wrap-around distance helper.
// No dependencies.
`timescale 1ns / 1ps

package tfcp_pkg;

	localparam int FRAME_WIDTH  = 128;
	localparam int FRAME_HEIGHT = 128;
	localparam int FRAME_WORDS  = FRAME_WIDTH * FRAME_HEIGHT;

	localparam int XW  = $clog2(FRAME_WIDTH);
	localparam int YW  = $clog2(FRAME_HEIGHT);
	localparam int CW  = (XW > YW) ? XW : YW;
	localparam int LW  = (CW + 1 > 8) ? CW + 1 : 8;
	localparam int AW  = $clog2(FRAME_WORDS);

	localparam int OPW = 2;
	localparam int PXW = 7;
	localparam int RW  = 10;
	localparam int SW  = RW - 4;
	localparam int CLW = 16;
	localparam int R2W = 2 * RW;
	localparam int MW  = (CW > RW) ? CW : RW;
	localparam int PW  = 2 * MW;

	localparam int IN_W  = 40;
	localparam int OUT_W = 16;

	localparam logic [OPW-1:0] OP_DRAW  = 2'd0;
	localparam logic [OPW-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPW-1:0] OP_READ  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_RSQ,
		ST_ROW,
		ST_PIX,
		ST_DRAIN,
		ST_CLR,
		ST_RD,
		ST_RDW,
		ST_DONE
	} state_t;

	// shortest distance between two coordinates on a ring of the given size
	function automatic logic [CW-1:0] tor_dist(input logic [CW-1:0] p, input logic [CW-1:0] c,
		input logic [LW-1:0] size);
		logic [CW-1:0] a;
		logic [LW-1:0] b;
		a = (p >= c) ? p - c : c - p;
		b = size - LW'(a);
		return (LW'(a) > b) ? CW'(b) : a;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] row, input logic [CW-1:0] col);
		return AW'(int'(row) * FRAME_WIDTH + int'(col));
	endfunction

endpackage

[src/tfcp_sq_unit.sv]
// Shared squaring unit of the painter: one multiplier, followed by the
// distance-against-radius compare used by the pixel stage. Uses tfcp_pkg.
`timescale 1ns / 1ps

module tfcp_sq_unit (
	input  logic [tfcp_pkg::MW-1:0]  opnd,
	input  logic [tfcp_pkg::PW-1:0]  addend,
	input  logic [tfcp_pkg::R2W-1:0] limit,
	output logic [tfcp_pkg::PW-1:0]  prod,
	output logic                     hit
);
	import tfcp_pkg::*;

	localparam int SHW = PW + 9;

	logic [PW:0] sum;

	assign prod = PW'(opnd) * PW'(opnd);
	assign sum  = {1'b0, prod} + {1'b0, addend};
	assign hit  = ((SHW'(sum) << 8) < SHW'(limit));

endmodule

[src/toroidal_filled_circle_painter_unit.sv]
// Top level of the toroidal filled-circle painter: stream ports, sequencer,
// frame memory and result register. Uses tfcp_pkg and tfcp_sq_unit.
`timescale 1ns / 1ps

// One item is taken at a time; s_tready is high only while the block is idle. A
// finished result waits in the output register while the next item is taken and
// worked on; that item stalls in its last cycle only while the earlier word is
// still unaccepted. A read passes through ST_RD and ST_RDW; a clear writes all
// FRAME_WIDTH*FRAME_HEIGHT frame words, one frame word written per cycle. A draw with
// s = (radius_q4 - 1) >> 4 walks a box of n = min(2s+1, FRAME_WIDTH) columns by
// m = min(2s+1, FRAME_HEIGHT) rows, one pixel per cycle within a row; the single
// shared multiplier squares the radius once, each row distance once and each
// column distance per pixel. A zero radius or an unused op code goes straight
// from ST_PREP to ST_DONE.
// The frame is not cleared at reset: clear it before reading.
module toroidal_filled_circle_painter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [tfcp_pkg::IN_W-1:0]  s_tdata,  // x_pos[6:0], y_pos[13:7], radius_q4[23:14], color[39:24]
	input  logic [tfcp_pkg::OPW-1:0]   s_tuser,  // op[1:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [tfcp_pkg::OUT_W-1:0] m_tdata,  // pixel_value[15:0]
	output logic [tfcp_pkg::OPW-1:0]   m_tuser   // op_echo[1:0]
);
	import tfcp_pkg::*;

	state_t state_q, state_d;

	logic [OPW-1:0] op_q;
	logic [PXW-1:0] xm_q, ym_q;
	logic [RW-1:0]  rad_q;
	logic [CLW-1:0] color_q;

	logic [CW-1:0]  px_q, py_q, x0_q;
	logic [LW-1:0]  nx_q, col_left_q, row_left_q;
	logic [R2W-1:0] r2_q;
	logic [PW-1:0]  ty2_q;
	logic [AW-1:0]  clr_addr_q;

	logic           v_s1;
	logic [CW-1:0]  tx_s1;
	logic [AW-1:0]  addr_s1;

	logic [CLW-1:0] frame_mem [FRAME_WORDS];
	logic [CLW-1:0] rd_q, pix_q;
	logic [AW-1:0]  rd_addr;

	logic           out_valid_q;
	logic [OPW-1:0] out_op_q;
	logic [CLW-1:0] out_pix_q;

	logic [CW-1:0]  cx, cy, ty, sc_x, sc_y, x0_c, y0_c;
	logic [SW-1:0]  span;
	logic [LW-1:0]  box, nx_c, ny_c;
	logic           x_big, y_big, out_free;

	logic [MW-1:0]  mul_opnd;
	logic [PW-1:0]  mul_prod;
	logic           mul_hit;
	logic           mem_we;
	logic [AW-1:0]  mem_wa;

	assign cx    = CW'(xm_q);
	assign cy    = CW'(ym_q);
	assign ty    = tor_dist(py_q, cy, LW'(FRAME_HEIGHT));
	assign x_big = (LW'(xm_q) >= LW'(FRAME_WIDTH));
	assign y_big = (LW'(ym_q) >= LW'(FRAME_HEIGHT));

	assign span = SW'((rad_q - 1'b1) >> 4);
	assign box  = LW'({span, 1'b1});
	assign nx_c = (box > LW'(FRAME_WIDTH)) ? LW'(FRAME_WIDTH) : box;
	assign ny_c = (box > LW'(FRAME_HEIGHT)) ? LW'(FRAME_HEIGHT) : box;
	assign sc_x = (LW'(span) > LW'(FRAME_WIDTH - 1)) ? CW'(FRAME_WIDTH - 1) : CW'(span);
	assign sc_y = (LW'(span) > LW'(FRAME_HEIGHT - 1)) ? CW'(FRAME_HEIGHT - 1) : CW'(span);
	assign x0_c = (cx >= sc_x) ? cx - sc_x : cx + CW'(FRAME_WIDTH) - sc_x;
	assign y0_c = (cy >= sc_y) ? cy - sc_y : cy + CW'(FRAME_HEIGHT) - sc_y;

	assign rd_addr  = addr_of(cy, cx);
	assign out_free = !out_valid_q || m_tready;

	tfcp_sq_unit u_sq (
		.opnd   (mul_opnd),
		.addend (ty2_q),
		.limit  (r2_q),
		.prod   (mul_prod),
		.hit    (mul_hit)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_PREP;
			end
			ST_PREP: begin
				if (!x_big && !y_big) begin
					case (op_q)
						OP_DRAW:  state_d = (rad_q == '0) ? ST_DONE : ST_RSQ;
						OP_CLEAR: state_d = ST_CLR;
						OP_READ:  state_d = ST_RD;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_RSQ: state_d = ST_ROW;
			ST_ROW: begin
				if (!v_s1) state_d = ST_PIX;
			end
			ST_PIX: begin
				if (col_left_q == LW'(1)) state_d = (row_left_q == LW'(1)) ? ST_DRAIN : ST_ROW;
			end
			ST_DRAIN: begin
				if (!v_s1) state_d = ST_DONE;
			end
			ST_CLR: begin
				if (clr_addr_q == AW'(FRAME_WORDS - 1)) state_d = ST_DONE;
			end
			ST_RD:  state_d = ST_RDW;
			ST_RDW: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		if (v_s1) mul_opnd = MW'(tx_s1);
		else if (state_q == ST_ROW) mul_opnd = MW'(ty);
		else mul_opnd = MW'(rad_q);
		mem_we = (state_q == ST_CLR) || (v_s1 && mul_hit);
		mem_wa = (state_q == ST_CLR) ? clr_addr_q : addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
			px_q        <= '0;
			py_q        <= '0;
			col_left_q  <= '0;
			row_left_q  <= '0;
			clr_addr_q  <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_PIX);
			case (state_q)
				ST_IDLE: begin
					clr_addr_q <= '0;
				end
				ST_ROW: begin
					if (!v_s1) begin
						px_q       <= x0_q;
						col_left_q <= nx_q;
					end
				end
				ST_RSQ: begin
					py_q       <= y0_c;
					row_left_q <= ny_c;
				end
				ST_PIX: begin
					px_q       <= (px_q == CW'(FRAME_WIDTH - 1)) ? '0 : px_q + 1'b1;
					col_left_q <= col_left_q - 1'b1;
					if (col_left_q == LW'(1)) begin
						row_left_q <= row_left_q - 1'b1;
						py_q       <= (py_q == CW'(FRAME_HEIGHT - 1)) ? '0 : py_q + 1'b1;
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
				default: begin
				end
			endcase
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q    <= s_tuser;
			xm_q    <= s_tdata[6:0];
			ym_q    <= s_tdata[13:7];
			rad_q   <= s_tdata[23:14];
			color_q <= s_tdata[39:24];
		end
		if (state_q == ST_PREP) begin
			if (x_big) xm_q <= xm_q - PXW'(FRAME_WIDTH);
			else if (y_big) ym_q <= ym_q - PXW'(FRAME_HEIGHT);
		end
		if (state_q == ST_RSQ) begin
			r2_q <= R2W'(mul_prod);
			nx_q <= nx_c;
			x0_q <= x0_c;
		end
		if (state_q == ST_ROW && !v_s1) ty2_q <= mul_prod;
		if (state_q == ST_PIX) begin
			tx_s1   <= tor_dist(px_q, cx, LW'(FRAME_WIDTH));
			addr_s1 <= addr_of(py_q, px_q);
		end
		if (state_q == ST_RDW) pix_q <= rd_q;
		if (state_q == ST_DONE && out_free) begin
			out_op_q  <= op_q;
			out_pix_q <= (op_q == OP_READ) ? pix_q : '0;
		end
	end

	// frame memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) frame_mem[mem_wa] <= color_q;
		rd_q <= frame_mem[rd_addr];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = out_op_q;

endmodule

[src/tfcp_checker.sv]
// Port-level checks for the toroidal filled-circle painter, bound to the top
// level. Uses tfcp_pkg; follows toroidal_filled_circle_painter_unit.
`timescale 1ns / 1ps

module tfcp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [tfcp_pkg::IN_W-1:0]  s_tdata,
	input logic [tfcp_pkg::OPW-1:0]   s_tuser,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [tfcp_pkg::OUT_W-1:0] m_tdata,
	input logic [tfcp_pkg::OPW-1:0]   m_tuser
);
	import tfcp_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after taking a word");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared in the cycle after the input word");

	a_zero_unless_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != OP_READ |-> m_tdata == '0)
		else $error("non-read result carries a pixel value");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

endmodule

bind toroidal_filled_circle_painter_unit tfcp_checker u_tfcp_checker (.*);

[sim/toroidal_filled_circle_painter_unit_check.sv]
// Result checker for toroidal_filled_circle_painter_unit: keeps its own copy of the
// frame, predicts each result word from the accepted input words and compares.
// Depends on tfcp_pkg only.
`timescale 1ns / 1ps

module toroidal_filled_circle_painter_unit_check (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [tfcp_pkg::IN_W-1:0]  s_tdata,
	input  logic [tfcp_pkg::OPW-1:0]   s_tuser,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [tfcp_pkg::OUT_W-1:0] m_tdata,
	input  logic [tfcp_pkg::OPW-1:0]   m_tuser,
	output int                         mismatches,
	output int                         outstanding
);
	import tfcp_pkg::*;

	typedef struct packed {
		logic [OPW-1:0] op_echo;
		logic [CLW-1:0] pixel_value;
	} answer_t;

	answer_t        answers[$];
	logic [CLW-1:0] frame_copy [0:FRAME_WORDS-1];
	int             words_seen;

	// nearest of the three images along one axis
	function automatic int ring_gap(input int c, input int p, input int size);
		int best, d, k;
		best = 1 << 30;
		for (k = -1; k <= 1; k++) begin
			d = c + k * size - p;
			if (d < 0)
				d = -d;
			if (d < best)
				best = d;
		end
		return best;
	endfunction

	task automatic paint_disc(input int cx, input int cy, input logic [RW-1:0] rq4,
		input logic [CLW-1:0] colour);
		int col_sq [FRAME_WIDTH];
		int row_sq [FRAME_HEIGHT];
		int r2, i, j, d;
		r2 = int'(rq4) * int'(rq4);
		if (r2 == 0)
			return;
		for (i = 0; i < FRAME_WIDTH; i++) begin
			d = ring_gap(cx, i, FRAME_WIDTH);
			col_sq[i] = d * d;
		end
		for (j = 0; j < FRAME_HEIGHT; j++) begin
			d = ring_gap(cy, j, FRAME_HEIGHT);
			row_sq[j] = d * d;
		end
		for (j = 0; j < FRAME_HEIGHT; j++)
			for (i = 0; i < FRAME_WIDTH; i++)
				if ((row_sq[j] + col_sq[i]) * 256 < r2)
					frame_copy[j * FRAME_WIDTH + i] = colour;
	endtask

	task automatic predict_word(input logic [OPW-1:0] op, input logic [IN_W-1:0] w);
		int             x, y, k;
		logic [RW-1:0]  rq4;
		logic [CLW-1:0] colour;
		answer_t        a;
		x      = int'(w[PXW-1:0]) % FRAME_WIDTH;
		y      = int'(w[2*PXW-1:PXW]) % FRAME_HEIGHT;
		rq4    = w[2*PXW+RW-1:2*PXW];
		colour = w[IN_W-1:2*PXW+RW];
		a.op_echo     = op;
		a.pixel_value = '0;
		case (op)
			OP_DRAW: begin
				paint_disc(x, y, rq4, colour);
			end
			OP_CLEAR: begin
				for (k = 0; k < FRAME_WORDS; k++)
					frame_copy[k] = colour;
			end
			OP_READ: begin
				a.pixel_value = frame_copy[y * FRAME_WIDTH + x];
			end
			default: begin
			end
		endcase
		answers.push_back(a);
	endtask

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		answer_t a;
		if (!arst_n) begin
			answers.delete();
			mismatches  = 0;
			outstanding = 0;
			words_seen  = 0;
		end else begin
			// compare first: a result and the next input word may meet on one edge
			if (m_tvalid && m_tready) begin
				if (answers.size() == 0) begin
					note_failure($sformatf("unexpected result word op_echo %0d pixel_value %h",
						m_tuser, m_tdata));
				end else begin
					a = answers.pop_front();
					if (m_tuser !== a.op_echo || m_tdata !== a.pixel_value[OUT_W-1:0])
						note_failure($sformatf(
							"result %0d: op_echo %0d (expected %0d), pixel_value %h (expected %h)",
							words_seen, m_tuser, a.op_echo, m_tdata, a.pixel_value));
				end
				words_seen++;
			end
			if (s_tvalid && s_tready)
				predict_word(s_tuser, s_tdata);
			outstanding = answers.size();
		end
	end

endmodule

[sim/toroidal_filled_circle_painter_unit_test.sv]
// Testbench top for toroidal_filled_circle_painter_unit: clock, reset, stimulus and
// verdict. Depends on tfcp_pkg, the block and toroidal_filled_circle_painter_unit_check.
`timescale 1ns / 1ps

module toroidal_filled_circle_painter_unit_test;
	import tfcp_pkg::*;

	localparam logic [OPW-1:0] OP_SPARE    = 2'd3;
	localparam int             CYCLE_LIMIT = 12_000_000;
	localparam int             NARROW_MAX  = 160;
	localparam int             RANDOM_WORDS = 116;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [OPW-1:0]   s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [OPW-1:0]   m_tuser;

	int mismatches, outstanding;
	int cycles = 0;
	bit calm;
	int last_cx, last_cy, last_r;
	int n_draw, n_wide, n_clear, n_read, n_spare;

	toroidal_filled_circle_painter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	toroidal_filled_circle_painter_unit_check painter_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: stall in bursts, hold ready high once calm
	initial begin
		int n;
		m_tready = 1'b0;
		forever begin
			if (calm) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 19);
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				n = $urandom_range(1, 30);
				@(negedge clk);
				m_tready <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_word(input logic [OPW-1:0] op, input logic [PXW-1:0] x,
		input logic [PXW-1:0] y, input logic [RW-1:0] r, input logic [CLW-1:0] colour);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 19);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {colour, r, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		case (op)
			OP_DRAW: begin
				n_draw++;
				if (int'(r) > NARROW_MAX)
					n_wide++;
				last_cx = int'(x);
				last_cy = int'(y);
				last_r  = int'(r);
			end
			OP_CLEAR: n_clear++;
			OP_READ:  n_read++;
			default:  n_spare++;
		endcase
	endtask

	task automatic send_random_word();
		int k, span, x, y, r;
		k = $urandom_range(0, 99);
		if (k < 3) begin
			send_word(OP_CLEAR, PXW'($urandom), PXW'($urandom), RW'($urandom),
				CLW'($urandom));
		end else if (k < 8) begin
			send_word(OP_SPARE, PXW'($urandom), PXW'($urandom), RW'($urandom),
				CLW'($urandom));
		end else if (k < 45) begin
			r = ($urandom_range(0, 15) == 0) ? $urandom_range(NARROW_MAX + 1, 1023)
				: $urandom_range(0, NARROW_MAX);
			send_word(OP_DRAW, PXW'($urandom), PXW'($urandom), RW'(r), CLW'($urandom));
		end else begin
			// aim most reads at the box around the latest disc
			if ($urandom_range(0, 9) < 7) begin
				span = last_r / 16 + 2;
				x = last_cx + $urandom_range(0, 2 * span) - span;
				y = last_cy + $urandom_range(0, 2 * span) - span;
			end else begin
				x = $urandom;
				y = $urandom;
			end
			send_word(OP_READ, PXW'(x), PXW'(y), RW'($urandom), CLW'($urandom));
		end
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	initial begin
		int i;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = OP_DRAW;
		calm     = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed part
		send_word(OP_DRAW,  7'd5,   7'd5,   10'd48,   16'h0F0F);
		send_word(OP_CLEAR, 7'd127, 7'd127, 10'd1023, 16'h0000);
		send_word(OP_READ,  7'd0,   7'd0,   10'd0,    16'hFFFF);
		send_word(OP_DRAW,  7'd0,   7'd0,   10'd40,   16'hFFFF);
		send_word(OP_READ,  7'd127, 7'd127, 10'd0,    16'h0000);
		send_word(OP_READ,  7'd2,   7'd2,   10'd0,    16'h0000);
		send_word(OP_DRAW,  7'd127, 7'd64,  10'd0,    16'h1234);
		send_word(OP_READ,  7'd127, 7'd64,  10'd0,    16'h0000);
		send_word(OP_DRAW,  7'd64,  7'd127, 10'd1,    16'hA5A5);
		send_word(OP_READ,  7'd64,  7'd127, 10'd0,    16'h0000);
		send_word(OP_READ,  7'd64,  7'd0,   10'd0,    16'h0000);
		send_word(OP_DRAW,  7'd30,  7'd30,  10'd16,   16'h5A5A);
		send_word(OP_READ,  7'd31,  7'd30,  10'd0,    16'h0000);
		send_word(OP_READ,  7'd30,  7'd30,  10'd0,    16'h0000);
		send_word(OP_DRAW,  7'd100, 7'd20,  10'd17,   16'h3C3C);
		send_word(OP_READ,  7'd101, 7'd20,  10'd0,    16'h0000);
		send_word(OP_SPARE, 7'd127, 7'd0,   10'd1023, 16'hFFFF);
		send_word(OP_DRAW,  7'd64,  7'd64,  10'd1023, 16'h8001);
		send_word(OP_READ,  7'd0,   7'd0,   10'd0,    16'h0000);
		send_word(OP_READ,  7'd10,  7'd64,  10'd0,    16'h0000);
		send_word(OP_CLEAR, 7'd0,   7'd0,   10'd0,    16'hFFFF);
		send_word(OP_READ,  7'd77,  7'd13,  10'd0,    16'h0000);
		send_word(OP_DRAW,  7'd0,   7'd127, 10'd1023, 16'h0000);
		send_word(OP_READ,  7'd127, 7'd0,   10'd0,    16'h0000);

		// let the block drain completely once
		hold_until_drained();

		for (i = 0; i < RANDOM_WORDS; i++) begin
			if (i >= RANDOM_WORDS - 20)
				calm = 1'b1;
			send_random_word();
		end

		hold_until_drained();
		repeat (20) @(negedge clk);

		$display("covered %0d draws (%0d wide), %0d clears, %0d reads, %0d spare-code words",
			n_draw, n_wide, n_clear, n_read, n_spare);
		$display("in %0d cycles with stalls on both channels, %0d mismatches",
			cycles, mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
